FILE: design/skm_pkg.sv
// ----------------------------------------------------------------------------
// skm_pkg: shared types and codes for the sorted key map
// Word layouts, function and status codes, sequencer states.
// ----------------------------------------------------------------------------
package skm_pkg;

	localparam int unsigned CAPACITY_DEF = 64;

	localparam int unsigned FUNC_W = 2;
	localparam int unsigned KEY_W  = 32;
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned STAT_W = 3;
	localparam int unsigned LIVE_W = 7;

	localparam logic [FUNC_W-1:0] FN_ADD  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_FIND = 2'd1;
	localparam logic [FUNC_W-1:0] FN_DEL  = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
	localparam logic [STAT_W-1:0] ST_ORDER   = 3'd2;
	localparam logic [STAT_W-1:0] ST_MISSING = 3'd3;
	localparam logic [STAT_W-1:0] ST_ZERO    = 3'd4;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} skm_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  found_value;
		logic [LIVE_W-1:0] live_count;
	} skm_result_t;

	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
	} skm_cmp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_CHK,
		S_SEARCH,
		S_SQZ,
		S_SQZ_END
	} skm_state_t;

endpackage

FILE: design/skm_mem.sv
// ----------------------------------------------------------------------------
// skm_mem: key and handle store
// Two arrays sharing one read address with registered read data, and one
// write address with separate key and handle write enables.
// ----------------------------------------------------------------------------
module skm_mem import skm_pkg::*; #(
	parameter int unsigned DEPTH = CAPACITY_DEF,
	localparam int unsigned IDX_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	input  logic             wr_key_en,
	input  logic             wr_val_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [KEY_W-1:0] wr_key,
	input  logic [VAL_W-1:0] wr_val,
	output logic [KEY_W-1:0] rd_key_q,
	output logic [VAL_W-1:0] rd_val_q
);

	logic [KEY_W-1:0] key_mem   [DEPTH];
	logic [VAL_W-1:0] value_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_key_en) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (wr_val_en) begin
			value_mem[wr_addr] <= wr_val;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_val_q <= value_mem[rd_addr];
		end
	end

endmodule

FILE: design/skm_probe.sv
// ----------------------------------------------------------------------------
// skm_probe: binary search step
// Compares the probed key, narrows the search window and forms the next
// probe slot. Opens the window over all used slots on the first step.
// ----------------------------------------------------------------------------
module skm_probe import skm_pkg::*; #(
	parameter int unsigned CNT_W = 7
) (
	input  logic             first,
	input  logic [CNT_W-1:0] used,
	input  logic [CNT_W-1:0] lo,
	input  logic [CNT_W-1:0] hi,
	input  logic [KEY_W-1:0] rd_key,
	input  logic [KEY_W-1:0] key,
	output skm_cmp_t         cmp,
	output logic [CNT_W-1:0] lo_n,
	output logic [CNT_W-1:0] hi_n,
	output logic [CNT_W-1:0] mid_n,
	output logic             more
);

	logic [CNT_W-1:0] mid;

	always_comb begin
		mid    = lo + ((hi - lo) >> 1);
		cmp.lt = rd_key < key;
		cmp.eq = rd_key == key;
		cmp.gt = rd_key > key;
		lo_n   = lo;
		hi_n   = hi;
		if (first) begin
			lo_n = '0;
			hi_n = used;
		end else if (cmp.lt) begin
			lo_n = mid + CNT_W'(1);
		end else begin
			hi_n = mid;
		end
		more  = lo_n < hi_n;
		mid_n = lo_n + ((hi_n - lo_n) >> 1);
	end

endmodule

FILE: design/sorted_key_map_with_tombstones.sv
// ----------------------------------------------------------------------------
// sorted_key_map_with_tombstones: sorted key to handle map, lazy delete
// Command-style map over CAPACITY slots held in key order.
// ----------------------------------------------------------------------------
// Usage: drive item (func, key, value) and raise start; the word is taken on
// a clock edge where start is high and busy is low. busy then stays high
// until the answer is ready. The answer sits on result for exactly one cycle
// with done high; the receiver cannot stall it, and a new word may be
// started in that same cycle.
// Func 3 answers on the next cycle with busy never raised. Add passes through
// the order check, which reads the last used key when the table is not empty.
// Find and delete make one store read per binary search probe, paced by the
// single store read port. A find or delete on an empty table answers on the
// next cycle. An add to a full table with more than CAPACITY/4 tombstones
// first compacts the store, one slot read per cycle.
// Reset empties the table at once; the store contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_key_map_with_tombstones import skm_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  skm_item_t   item,
	output logic        busy,
	output logic        done,
	output skm_result_t result
);

	localparam int unsigned IDX_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C     = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] QUARTER_C = CNT_W'(CAPACITY / 4);

	skm_state_t state_q, state_d;

	logic [FUNC_W-1:0] func_q, func_d;
	logic [KEY_W-1:0]  key_q, key_d;
	logic [VAL_W-1:0]  value_q, value_d;
	logic [CNT_W-1:0]  used_q, used_d;
	logic [CNT_W-1:0]  dead_q, dead_d;
	logic [CNT_W-1:0]  lo_q, lo_d;
	logic [CNT_W-1:0]  hi_q, hi_d;
	logic [CNT_W-1:0]  mid_q, mid_d;
	logic [CNT_W-1:0]  sqz_rd_q, sqz_rd_d;
	logic [CNT_W-1:0]  sqz_wr_q, sqz_wr_d;
	logic              sqz_pend_q, sqz_pend_d;
	logic              done_q, done_d;
	logic [STAT_W-1:0] status_q, status_d;
	logic [VAL_W-1:0]  found_q, found_d;
	logic [CNT_W-1:0]  live;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_key_en;
	logic             wr_val_en;
	logic [IDX_W-1:0] wr_addr;
	logic [KEY_W-1:0] wr_key;
	logic [VAL_W-1:0] wr_val;
	logic [KEY_W-1:0] rd_key_q;
	logic [VAL_W-1:0] rd_val_q;

	skm_cmp_t         cmp;
	logic [CNT_W-1:0] lo_n;
	logic [CNT_W-1:0] hi_n;
	logic [CNT_W-1:0] mid_n;
	logic             more;

	skm_mem #(
		.DEPTH(CAPACITY)
	) u_mem (
		.clk      (clk),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.wr_key_en(wr_key_en),
		.wr_val_en(wr_val_en),
		.wr_addr  (wr_addr),
		.wr_key   (wr_key),
		.wr_val   (wr_val),
		.rd_key_q (rd_key_q),
		.rd_val_q (rd_val_q)
	);

	skm_probe #(
		.CNT_W(CNT_W)
	) u_probe (
		.first (state_q == S_IDLE),
		.used  (used_q),
		.lo    (lo_q),
		.hi    (hi_q),
		.rd_key(rd_key_q),
		.key   (key_q),
		.cmp   (cmp),
		.lo_n  (lo_n),
		.hi_n  (hi_n),
		.mid_n (mid_n),
		.more  (more)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			dead_q     <= '0;
			sqz_pend_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			used_q     <= used_d;
			dead_q     <= dead_d;
			sqz_pend_q <= sqz_pend_d;
			done_q     <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q   <= func_d;
		key_q    <= key_d;
		value_q  <= value_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		mid_q    <= mid_d;
		sqz_rd_q <= sqz_rd_d;
		sqz_wr_q <= sqz_wr_d;
		status_q <= status_d;
		found_q  <= found_d;
	end

	always_comb begin
		state_d    = state_q;
		func_d     = func_q;
		key_d      = key_q;
		value_d    = value_q;
		used_d     = used_q;
		dead_d     = dead_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		mid_d      = mid_q;
		sqz_rd_d   = sqz_rd_q;
		sqz_wr_d   = sqz_wr_q;
		sqz_pend_d = sqz_pend_q;
		done_d     = 1'b0;
		status_d   = status_q;
		found_d    = found_q;
		rd_en      = 1'b0;
		rd_addr    = '0;
		wr_key_en  = 1'b0;
		wr_val_en  = 1'b0;
		wr_addr    = '0;
		wr_key     = key_q;
		wr_val     = value_q;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					func_d  = item.func;
					key_d   = item.key;
					value_d = item.value;
					case (item.func) inside
						FN_ADD: begin
							// fetch the last used key for the order check
							rd_en   = used_q != '0;
							rd_addr = IDX_W'(used_q - CNT_W'(1));
							state_d = S_ADD_CHK;
						end
						FN_FIND, FN_DEL: begin
							if (more) begin
								rd_en   = 1'b1;
								rd_addr = mid_n[IDX_W-1:0];
								lo_d    = lo_n;
								hi_d    = hi_n;
								mid_d   = mid_n;
								state_d = S_SEARCH;
							end else begin
								done_d   = 1'b1;
								status_d = ST_MISSING;
								found_d  = '0;
							end
						end
						default: begin
							done_d   = 1'b1;
							status_d = ST_OK;
							found_d  = '0;
						end
					endcase
				end
			end
			S_ADD_CHK: begin
				found_d = '0;
				if (used_q != '0 && rd_key_q >= key_q) begin
					done_d   = 1'b1;
					status_d = ST_ORDER;
					state_d  = S_IDLE;
				end else if (value_q == '0) begin
					done_d   = 1'b1;
					status_d = ST_ZERO;
					state_d  = S_IDLE;
				end else if (used_q == CAP_C) begin
					if (dead_q > QUARTER_C) begin
						sqz_rd_d   = '0;
						sqz_wr_d   = '0;
						sqz_pend_d = 1'b0;
						state_d    = S_SQZ;
					end else begin
						done_d   = 1'b1;
						status_d = ST_FULL;
						state_d  = S_IDLE;
					end
				end else begin
					wr_key_en = 1'b1;
					wr_val_en = 1'b1;
					wr_addr   = IDX_W'(used_q);
					used_d    = used_q + CNT_W'(1);
					done_d    = 1'b1;
					status_d  = ST_OK;
					state_d   = S_IDLE;
				end
			end
			S_SEARCH: begin
				if (cmp.eq) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
					if (rd_val_q != '0) begin
						status_d = ST_OK;
						found_d  = rd_val_q;
						if (func_q == FN_DEL) begin
							// tombstone the slot; empty the table when all are dead
							wr_val_en = 1'b1;
							wr_addr   = mid_q[IDX_W-1:0];
							wr_val    = '0;
							if (dead_q + CNT_W'(1) == used_q) begin
								used_d = '0;
								dead_d = '0;
							end else begin
								dead_d = dead_q + CNT_W'(1);
							end
						end
					end else begin
						status_d = ST_MISSING;
						found_d  = '0;
					end
				end else if (more) begin
					rd_en   = 1'b1;
					rd_addr = mid_n[IDX_W-1:0];
					lo_d    = lo_n;
					hi_d    = hi_n;
					mid_d   = mid_n;
				end else begin
					done_d   = 1'b1;
					status_d = ST_MISSING;
					found_d  = '0;
					state_d  = S_IDLE;
				end
			end
			S_SQZ: begin
				// keep live slots, moving each down to the write pointer
				if (sqz_pend_q && rd_val_q != '0) begin
					wr_key_en = 1'b1;
					wr_val_en = 1'b1;
					wr_addr   = sqz_wr_q[IDX_W-1:0];
					wr_key    = rd_key_q;
					wr_val    = rd_val_q;
					sqz_wr_d  = sqz_wr_q + CNT_W'(1);
				end
				if (sqz_rd_q != used_q) begin
					rd_en      = 1'b1;
					rd_addr    = sqz_rd_q[IDX_W-1:0];
					sqz_rd_d   = sqz_rd_q + CNT_W'(1);
					sqz_pend_d = 1'b1;
				end else begin
					sqz_pend_d = 1'b0;
					if (!sqz_pend_q) begin
						state_d = S_SQZ_END;
					end
				end
			end
			S_SQZ_END: begin
				wr_key_en = 1'b1;
				wr_val_en = 1'b1;
				wr_addr   = sqz_wr_q[IDX_W-1:0];
				used_d    = sqz_wr_q + CNT_W'(1);
				dead_d    = '0;
				done_d    = 1'b1;
				status_d  = ST_OK;
				found_d   = '0;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// counts only change on an accepted word, so they are current while done is up
	assign live = used_q - dead_q;

	always_comb begin
		result.status      = status_q;
		result.found_value = found_q;
		result.live_count  = LIVE_W'(live);
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

endmodule

FILE: design/skm_checker.sv
// ----------------------------------------------------------------------------
// skm_checker: port-level checks for the sorted key map
// Watches the command and answer ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module skm_checker import skm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input skm_item_t   item,
	input logic        busy,
	input logic        done,
	input skm_result_t result
);

	// an answer is only given once the sequencer has let go
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while busy");

	// every finished word leaves an answer
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without an answer");

	// an add always goes busy for the order check
	a_add_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.func == FN_ADD) |=> busy)
		else $error("add taken without going busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> result.found_value == '0)
		else $error("failed answer carries a handle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_OK || result.status == ST_FULL ||
			result.status == ST_ORDER || result.status == ST_MISSING ||
			result.status == ST_ZERO))
		else $error("unknown status code");

endmodule

bind sorted_key_map_with_tombstones skm_checker u_skm_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.item  (item),
	.busy  (busy),
	.done  (done),
	.result(result)
);
